// ===== sv/assert_macros.svh =====
// Assertion helpers: every assertion is clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When ante holds, cons holds at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fps_pkg.sv =====
// -----------------------------------------------------------------------------
// fps_pkg
// Shared widths, codes and port types for the roulette-wheel selector.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fps_pkg;

  localparam int unsigned POP_SIZE  = 64;
  localparam int unsigned IDX_W     = $clog2(POP_SIZE);
  localparam int unsigned CNT_W     = $clog2(POP_SIZE + 1);

  localparam int unsigned WGT_W     = 4;
  localparam int unsigned MISS_W    = 8;
  localparam int unsigned TRAVEL_W  = 24;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned SCORE_W   = 28;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CMP_W     = SUM_W + FRAC_W;
  localparam int unsigned PICK_W    = 6;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_DRAW    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_W_MISSIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W_BONUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_COST     = 2'd2;

  localparam logic [WGT_W-1:0] W_MISSIONS_RST = 4'd5;
  localparam logic [WGT_W-1:0] W_BONUS_RST    = 4'd3;
  localparam logic [WGT_W-1:0] W_COST_RST     = 4'd2;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] r;
    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  count;
  } draw_req_t;

endpackage

// ===== sv/fps_score.sv =====
// -----------------------------------------------------------------------------
// fps_score
// Weighted fitness score of one individual, in units of tenths times 2^-8.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fps_score (
  input  logic [fps_pkg::WGT_W-1:0]    w_missions_i,
  input  logic [fps_pkg::WGT_W-1:0]    w_bonus_i,
  input  logic [fps_pkg::WGT_W-1:0]    w_cost_i,
  input  logic [fps_pkg::MISS_W-1:0]   missions_i,
  input  logic [fps_pkg::MISS_W-1:0]   matches_i,
  input  logic [fps_pkg::TRAVEL_W-1:0] travel_i,
  output logic [fps_pkg::SCORE_W-1:0]  score_o
);
  import fps_pkg::*;

  logic [MISS_W+WGT_W-1:0] miss_prod_w;
  logic [MISS_W+WGT_W-1:0] bonus_prod_w;
  logic [MISS_W+WGT_W:0]   count_sum_w;
  logic [SCORE_W-1:0]      cost_prod_w;

  assign miss_prod_w  = (MISS_W+WGT_W)'(w_missions_i) * (MISS_W+WGT_W)'(missions_i);
  assign bonus_prod_w = (MISS_W+WGT_W)'(w_bonus_i) * (MISS_W+WGT_W)'(matches_i);
  assign count_sum_w  = (MISS_W+WGT_W+1)'(miss_prod_w) + (MISS_W+WGT_W+1)'(bonus_prod_w);
  assign cost_prod_w  = SCORE_W'(w_cost_i) * SCORE_W'(travel_i);

  // scale the count terms by 2^8 to match the fraction bits of the cost
  assign score_o = (SCORE_W'(count_sum_w) << 8) + cost_prod_w;

endmodule

// ===== sv/fps_mem.sv =====
// -----------------------------------------------------------------------------
// fps_mem
// Cumulative score store: one write port, one registered read port.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fps_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [fps_pkg::IDX_W-1:0]  waddr_i,
  input  logic [fps_pkg::SUM_W-1:0]  wdata_i,
  input  fps_pkg::rd_req_t           rd_i,
  output logic [fps_pkg::SUM_W-1:0]  rdata_o
);
  import fps_pkg::*;

  logic [SUM_W-1:0] mem_q [POP_SIZE];
  logic [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fps_search.sv =====
// -----------------------------------------------------------------------------
// fps_search
// Draw engine: threshold multiply, then binary search of the cumulative store.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fps_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fps_pkg::draw_req_t         req_i,
  output logic                       busy_o,
  output fps_pkg::rd_req_t           rd_o,
  input  logic [fps_pkg::SUM_W-1:0]  rdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fps_pkg::PICK_W-1:0] picked_index_o,
  output logic                       no_pick_o
);
  import fps_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SRCH
  } state_e;

  state_e             state_q, state_d;
  logic [FRAC_W-1:0]  r_q, r_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CMP_W-1:0]   thr_q, thr_d;
  logic [IDX_W-1:0]   lo_q, lo_d;
  logic [IDX_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]   mid_q, mid_d;
  logic               pend_q, pend_d;
  logic               nopick_q, nopick_d;
  logic               out_valid_q, out_valid_d;
  logic [PICK_W-1:0]  out_idx_q, out_idx_d;
  logic               out_nopick_q, out_nopick_d;

  logic [CMP_W-1:0]   shifted_w;
  logic               hit_w;
  logic [IDX_W-1:0]   lo_n, hi_n;
  logic [IDX_W:0]     mid_sum_w;
  logic               out_free_w;
  logic               out_load_w;

  assign shifted_w  = {rdata_i, FRAC_W'(0)};
  assign hit_w      = shifted_w > thr_q;
  assign out_free_w = !out_valid_q || !out_stall_i;

  // narrow the window with the entry read in the previous cycle
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (pend_q) begin
      if (hit_w) begin
        hi_n = mid_q;
      end else begin
        lo_n = mid_q + IDX_W'(1);
      end
    end
  end

  assign mid_sum_w = (IDX_W+1)'(lo_n) + (IDX_W+1)'(hi_n);

  always_comb begin
    state_d      = state_q;
    r_d          = r_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    thr_d        = thr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    pend_d       = 1'b0;
    nopick_d     = nopick_q;
    out_idx_d    = out_idx_q;
    out_nopick_d = out_nopick_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_load_w   = 1'b0;
    rd_o         = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          r_d      = req_i.r;
          total_d  = req_i.total;
          cnt_d    = req_i.count;
          lo_d     = '0;
          hi_d     = (req_i.count == '0) ? '0 : IDX_W'(req_i.count - CNT_W'(1));
          nopick_d = (req_i.count == '0) || (req_i.total == '0);
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        thr_d   = CMP_W'(r_q) * CMP_W'(total_q);
        state_d = S_SRCH;
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (nopick_q || lo_n == hi_n) begin
          // hold the answer until the output register frees up
          if (out_free_w) begin
            out_load_w   = 1'b1;
            out_valid_d  = 1'b1;
            out_idx_d    = nopick_q ? '0 : PICK_W'(lo_n);
            out_nopick_d = nopick_q;
            state_d      = S_IDLE;
          end
        end else begin
          mid_d   = mid_sum_w[IDX_W:1];
          pend_d  = 1'b1;
          rd_o.en   = 1'b1;
          rd_o.addr = mid_sum_w[IDX_W:1];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q          <= r_d;
    total_q      <= total_d;
    cnt_q        <= cnt_d;
    thr_q        <= thr_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    nopick_q     <= nopick_d;
    out_idx_q    <= out_idx_d;
    out_nopick_q <= out_nopick_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign picked_index_o = out_idx_q;
  assign no_pick_o      = out_nopick_q;

  `ASSERT_ON(a_window_order, (state_q == S_SRCH && !nopick_q) |-> (lo_q <= hi_q),
    "search window inverted")
  `ASSERT_ON(a_mid_in_window, pend_q |-> (mid_q >= lo_q && mid_q < hi_q),
    "probe outside search window")
  `ASSERT_ON(a_pick_loaded, (out_load_w && !nopick_q) |-> (CNT_W'(lo_n) < cnt_q),
    "picked index beyond loaded count")
  `ASSERT_NEXT(a_start_idle, state_q != S_IDLE, !req_i.start || state_q == S_IDLE,
    "draw started while busy")

endmodule

// ===== sv/fitness_proportionate_selector.sv =====
// -----------------------------------------------------------------------------
// fitness_proportionate_selector
// Roulette-wheel selection over a loaded population of scored individuals.
// -----------------------------------------------------------------------------
// Load and restart transfers complete without stalling the input; the next item is taken at once.
// A draw runs a threshold multiply, then one store read per binary-search step, and only
// then registers its result; the input is stalled while a draw is under way.
// An empty store or a zero total answers without a store read. A stalled result register
// holds a finished draw and the input with it.
// Reset empties the store and sets the weights to 5, 3 and 2 tenths; entries are not cleared.
`timescale 1ns / 1ps

module fitness_proportionate_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fps_pkg::WGT_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fps_pkg::OP_W-1:0]         opcode_i,
  input  logic [fps_pkg::MISS_W-1:0]       missions_assigned_i,
  input  logic [fps_pkg::MISS_W-1:0]       specialty_matches_i,
  input  logic [fps_pkg::TRAVEL_W-1:0]     travel_cost_i,
  input  logic [fps_pkg::FRAC_W-1:0]       random_fraction_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fps_pkg::PICK_W-1:0]       picked_index_o,
  output logic                             no_pick_o
);
  import fps_pkg::*;

  logic [WGT_W-1:0]   w_missions_q, w_bonus_q, w_cost_q;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   count_q, count_d;

  logic               busy_w;
  logic               accept_w;
  logic [SCORE_W-1:0] score_w;
  logic               we_w;
  draw_req_t          draw_w;
  rd_req_t            rd_w;
  logic [SUM_W-1:0]   rdata_w;

  assign in_stall_o = busy_w;
  assign accept_w   = in_valid_i && !busy_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_missions_q <= W_MISSIONS_RST;
      w_bonus_q    <= W_BONUS_RST;
      w_cost_q     <= W_COST_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_W_MISSIONS: w_missions_q <= cfg_data_i;
        REG_W_BONUS:    w_bonus_q    <= cfg_data_i;
        REG_W_COST:     w_cost_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fps_score u_score (
    .w_missions_i (w_missions_q),
    .w_bonus_i    (w_bonus_q),
    .w_cost_i     (w_cost_q),
    .missions_i   (missions_assigned_i),
    .matches_i    (specialty_matches_i),
    .travel_i     (travel_cost_i),
    .score_o      (score_w)
  );

  always_comb begin
    total_d      = total_q;
    count_d      = count_q;
    we_w         = 1'b0;
    draw_w       = '0;
    draw_w.r     = random_fraction_i;
    draw_w.total = total_q;
    draw_w.count = count_q;
    if (accept_w) begin
      case (op_e'(opcode_i))
        OP_LOAD: begin
          // drop loads into a full store
          if (count_q < CNT_W'(POP_SIZE)) begin
            total_d = total_q + SUM_W'(score_w);
            count_d = count_q + CNT_W'(1);
            we_w    = 1'b1;
          end
        end
        OP_DRAW: begin
          draw_w.start = 1'b1;
        end
        OP_RESTART: begin
          total_d = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      count_q <= '0;
    end else begin
      total_q <= total_d;
      count_q <= count_d;
    end
  end

  fps_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (total_d),
    .rd_i    (rd_w),
    .rdata_o (rdata_w)
  );

  fps_search u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (draw_w),
    .busy_o         (busy_w),
    .rd_o           (rd_w),
    .rdata_i        (rdata_w),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .picked_index_o (picked_index_o),
    .no_pick_o      (no_pick_o)
  );

endmodule
